@@ src/usbdc_pkg.sv @@
// Package for the USB descriptor checker: item and result types, the record
// passed from the front end to the back end, and descriptor constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package usbdc_pkg;

  localparam int MAX_ENDPOINTS = 16;
  localparam int FILL_W        = $clog2(MAX_ENDPOINTS + 1);
  localparam int EP_IDX_W      = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

  localparam int CAPTURE_DEPTH = 12;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_DEVICE   = 1'b0;
  localparam logic KIND_ENDPOINT = 1'b1;

  localparam logic [7:0] DEV_LEN_MIN   = 8'd18;
  localparam logic [7:0] EP_LEN_MIN    = 8'd7;
  localparam logic [7:0] TYPE_DEVICE   = 8'd1;
  localparam logic [7:0] TYPE_ENDPOINT = 8'd5;
  localparam logic [7:0] BCD_USB_LO    = 8'h00;
  localparam logic [7:0] BCD_USB_HI    = 8'h02;
  localparam logic [7:0] BYTE_MAX      = 8'd255;

  localparam logic [6:0]  EP_NUM_MASK     = 7'h7f;
  localparam logic [6:0]  EP_NUM_MAX      = 7'h0f;
  localparam logic [15:0] PACKET_SIZE_MAX = 16'd64;
  localparam logic [15:0] PACKET_HI_MASK  = 16'hf800;

  localparam logic [1:0] XFER_CONTROL   = 2'd0;
  localparam logic [1:0] XFER_BULK      = 2'd2;
  localparam logic [1:0] XFER_INTERRUPT = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last;
  } desc_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  class_code;
    logic [7:0]  subclass_code;
    logic [7:0]  protocol_code;
    logic [4:0]  endpoint_total;
    logic [7:0]  ep_address;
    logic [7:0]  ep_attributes;
    logic [6:0]  ep_packet_size;
    logic [7:0]  ep_interval;
  } result_t;

  // One finished descriptor after the checks that need no table state.
  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  dev_class;
    logic [7:0]  dev_subclass;
    logic [7:0]  dev_protocol;
    logic [7:0]  addr;
    logic [7:0]  attr;
    logic [6:0]  packet_size;
    logic [7:0]  interval;
  } desc_rec_t;

  function automatic logic pkt_pow2(input logic [15:0] p);
    return (p == 16'd8) || (p == 16'd16) || (p == 16'd32) || (p == 16'd64);
  endfunction

endpackage

@@ src/usbdc_front.sv @@
// Front end of the USB descriptor checker: captures descriptor bytes, counts
// them and runs the stateless field checks on the last byte.
// Depends on usbdc_pkg.
`timescale 1ns / 1ps

module usbdc_front import usbdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  desc_t     item,
  output logic      push,
  output desc_rec_t rec
);

  logic [7:0] cap [CAPTURE_DEPTH];
  logic [7:0] byte_count;
  logic [7:0] byte_count_next;
  logic       kind_latch;
  logic       kind;
  logic [7:0] view [CAPTURE_DEPTH];
  logic [7:0] len;
  logic [15:0] mp;
  logic [1:0]  ttype;
  logic [6:0]  ep_num;
  logic        dev_ok;
  logic        ep_ok;

  assign byte_count_next = (byte_count == BYTE_MAX) ? BYTE_MAX : byte_count + 8'd1;
  assign len  = byte_count_next;
  assign kind = (byte_count == 8'd0) ? item.cmd : kind_latch;

  // The byte arriving now is merged into the captured bytes so the checks
  // see the complete descriptor on its last byte.
  always_comb begin
    for (int i = 0; i < CAPTURE_DEPTH; i++) begin
      view[i] = (byte_count == 8'(i)) ? item.data_byte : cap[i];
    end
  end

  assign mp     = {view[5], view[4]};
  assign ttype  = view[3][1:0];
  assign ep_num = view[2][6:0] & EP_NUM_MASK;

  always_comb begin
    dev_ok = (len >= DEV_LEN_MIN) && (view[0] >= DEV_LEN_MIN) && (view[0] <= len) &&
             (view[1] == TYPE_DEVICE) && (view[2] == BCD_USB_LO) &&
             (view[3] == BCD_USB_HI) && ({view[9], view[8]} != 16'd0) &&
             pkt_pow2({8'd0, view[7]});
    ep_ok  = (len >= EP_LEN_MIN) && (view[0] >= EP_LEN_MIN) && (view[0] <= len) &&
             (view[1] == TYPE_ENDPOINT) && (ep_num != 7'd0) && (ep_num <= EP_NUM_MAX) &&
             (ttype != XFER_CONTROL) &&
             !((ttype == XFER_INTERRUPT) && (view[6] == 8'd0)) &&
             (mp != 16'd0) && ((mp & PACKET_HI_MASK) == 16'd0) &&
             (mp <= PACKET_SIZE_MAX) &&
             !((ttype == XFER_BULK) && !pkt_pow2(mp));
  end

  always_comb begin
    rec.kind         = kind;
    rec.ok           = (kind == KIND_DEVICE) ? dev_ok : ep_ok;
    rec.vendor       = {view[9], view[8]};
    rec.product      = {view[11], view[10]};
    rec.dev_class    = view[4];
    rec.dev_subclass = view[5];
    rec.dev_protocol = view[6];
    rec.addr         = view[2];
    rec.attr         = view[3];
    rec.packet_size  = view[4][6:0];
    rec.interval     = view[6];
  end

  assign push = accept && item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 8'd0;
      kind_latch <= KIND_DEVICE;
    end else if (accept) begin
      byte_count <= item.last ? 8'd0 : byte_count_next;
      kind_latch <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        if (byte_count == 8'(i)) cap[i] <= item.data_byte;
      end
    end
  end

endmodule

@@ src/usbdc_queue.sv @@
// Short queue of checked descriptor records between front and back end.
// Depends on usbdc_pkg.
`timescale 1ns / 1ps

module usbdc_queue import usbdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  desc_rec_t push_rec,
  input  logic      pop,
  output desc_rec_t pop_rec,
  output logic      full,
  output logic      empty
);

  desc_rec_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

endmodule

@@ src/usbdc_back.sv @@
// Back end of the USB descriptor checker: holds the device fields and the
// endpoint address table, applies descriptors and registers the result.
// Depends on usbdc_pkg.
`timescale 1ns / 1ps

module usbdc_back import usbdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  desc_rec_t rec,
  input  logic      rec_avail,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result
);

  logic [15:0]       stored_vendor;
  logic [15:0]       stored_product;
  logic [7:0]        stored_class;
  logic [7:0]        stored_subclass;
  logic [7:0]        stored_protocol;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        addr_tab [MAX_ENDPOINTS];
  logic              dup;
  logic              room;
  logic              dev_take;
  logic              ep_take;
  result_t           result_next;

  assign pop = rec_avail && (!result_valid || !result_stall);

  // Only entries below the fill count hold live addresses.
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_ENDPOINTS; i++) begin
      if ((FILL_W'(i) < fill) && (addr_tab[i] == rec.addr)) dup = 1'b1;
    end
  end

  assign room     = (fill < FILL_W'(MAX_ENDPOINTS));
  assign dev_take = pop && rec.ok && (rec.kind == KIND_DEVICE);
  assign ep_take  = pop && rec.ok && (rec.kind == KIND_ENDPOINT) && room && !dup;

  always_comb begin
    if (dev_take)     fill_next = '0;
    else if (ep_take) fill_next = fill + FILL_W'(1);
    else              fill_next = fill;
  end

  always_comb begin
    result_next.accepted       = dev_take || ep_take;
    result_next.vendor         = dev_take ? rec.vendor       : stored_vendor;
    result_next.product        = dev_take ? rec.product      : stored_product;
    result_next.class_code     = dev_take ? rec.dev_class    : stored_class;
    result_next.subclass_code  = dev_take ? rec.dev_subclass : stored_subclass;
    result_next.protocol_code  = dev_take ? rec.dev_protocol : stored_protocol;
    result_next.endpoint_total = 5'(fill_next);
    result_next.ep_address     = ep_take ? rec.addr        : 8'd0;
    result_next.ep_attributes  = ep_take ? rec.attr        : 8'd0;
    result_next.ep_packet_size = ep_take ? rec.packet_size : 7'd0;
    result_next.ep_interval    = ep_take ? rec.interval    : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_vendor   <= 16'd0;
      stored_product  <= 16'd0;
      stored_class    <= 8'd0;
      stored_subclass <= 8'd0;
      stored_protocol <= 8'd0;
      fill            <= '0;
      result_valid    <= 1'b0;
    end else begin
      fill <= fill_next;
      if (dev_take) begin
        stored_vendor   <= rec.vendor;
        stored_product  <= rec.product;
        stored_class    <= rec.dev_class;
        stored_subclass <= rec.dev_subclass;
        stored_protocol <= rec.dev_protocol;
      end
      if (pop)               result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) result <= result_next;
    if (ep_take) addr_tab[fill[EP_IDX_W-1:0]] <= rec.addr;
  end

endmodule

@@ src/usb_descriptor_checker_endpoint_table_unit.sv @@
// USB descriptor checker with endpoint table. Descriptor bytes are taken one
// per cycle with no gaps needed while the record queue has room; the byte
// marked last yields one result, which passes through the record queue (two
// entries) and the result register. A new byte is refused only while the
// record queue is full. The endpoint address compare over the table is
// combinational, so results drain at one per cycle while result_stall is low.
// Depends on usbdc_pkg, usbdc_front, usbdc_queue and usbdc_back.
`timescale 1ns / 1ps

module usb_descriptor_checker_endpoint_table_unit import usbdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    desc_valid,
  output logic    desc_stall,
  input  desc_t   desc,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic      accept;
  logic      push;
  desc_rec_t push_rec;
  desc_rec_t pop_rec;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  assign desc_stall = q_full;
  assign accept     = desc_valid && !desc_stall;

  usbdc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (desc),
    .push   (push),
    .rec    (push_rec)
  );

  usbdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  usbdc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec          (pop_rec),
    .rec_avail    (!q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A rejected descriptor never reports endpoint fields.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.accepted |->
      result.ep_address == 8'd0 && result.ep_packet_size == 7'd0 &&
      result.ep_attributes == 8'd0 && result.ep_interval == 8'd0)
    else $error("rejected descriptor carries endpoint fields");

  // An added endpoint has a legal packet size and leaves a nonempty table.
  a_ep_added: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.ep_address != 8'd0 |->
      result.accepted && result.endpoint_total != 5'd0 &&
      result.ep_packet_size != 7'd0 && result.ep_packet_size <= 7'd64)
    else $error("endpoint result inconsistent");

  // The queue never takes a record while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("record pushed into full queue");

endmodule
